/* design/log_frame_parser_unit_defines.svh */
// assertion macros shared by the parser rtl
`ifndef LOG_FRAME_PARSER_UNIT_DEFINES_SVH
`define LOG_FRAME_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lfp_pkg.sv */
`timescale 1ns / 1ps

package lfp_pkg;

    // record tags
    localparam logic [7:0] TAG_ERROR = 8'd11;
    localparam logic [7:0] TAG_PRINT = 8'd12;

    // result kinds
    localparam logic [1:0] KIND_MSG_HDR   = 2'd0;
    localparam logic [1:0] KIND_ERR_HDR   = 2'd1;
    localparam logic [1:0] KIND_TEXT      = 2'd2;
    localparam logic [1:0] KIND_FRAME_END = 2'd3;

    // text field codes
    localparam logic [1:0] FIELD_DETAILS  = 2'd0;
    localparam logic [1:0] FIELD_LOCATION = 2'd1;
    localparam logic [1:0] FIELD_STACK    = 2'd2;
    localparam logic [1:0] FIELD_PRINT    = 2'd3;

    // parse phases, one-hot
    typedef enum logic [12:0] {
        PH_LEN_HI  = 13'b0000000000001,
        PH_LEN_LO  = 13'b0000000000010,
        PH_TAG     = 13'b0000000000100,
        PH_TS      = 13'b0000000001000,
        PH_SEQ     = 13'b0000000010000,
        PH_OCC     = 13'b0000000100000,
        PH_CODE    = 13'b0000001000000,
        PH_FLAGS   = 13'b0000010000000,
        PH_STRLEN  = 13'b0000100000000,
        PH_STRBODY = 13'b0001000000000,
        PH_PRINT   = 13'b0010000000000,
        PH_TRAIL   = 13'b0100000000000,
        PH_IGNORE  = 13'b1000000000000
    } phase_t;

    // one result beat
    typedef struct packed {
        logic [1:0]  kind;
        logic        is_error;
        logic [31:0] timestamp;
        logic [15:0] seq;
        logic [15:0] occ;
        logic [31:0] code;
        logic [7:0]  flags;
        logic [1:0]  text_field;
        logic [7:0]  text_byte;
        logic        frame_end;
        logic        malformed;
    } lfp_event_t;

endpackage

/* design/lfp_parser.sv */
`timescale 1ns / 1ps

module lfp_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        byte_in,
    output logic              ev_valid,
    output lfp_pkg::lfp_event_t ev
);
    import lfp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] frame_rem_reg, frame_rem_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] shift_reg, shift_next;
    logic        tag_err_reg, tag_err_next;
    logic [15:0] str_rem_reg, str_rem_next;
    logic [1:0]  sel_reg, sel_next;
    logic [31:0] held_ts_reg, held_ts_next;
    logic [15:0] held_occ_reg, held_occ_next;

    logic        last;
    logic        quiet;
    logic [15:0] len;
    logic [15:0] rem_dec;
    logic [15:0] str_dec;
    logic [31:0] shifted;

    // byte shifted into the field assembly register
    assign shifted = {shift_reg[23:0], byte_in};
    assign len     = {shift_reg[7:0], byte_in};
    assign rem_dec = frame_rem_reg - 16'd1;
    assign str_dec = str_rem_reg - 16'd1;

    // next state and result for the byte at hand
    always_comb
    begin
        phase_next     = phase_reg;
        frame_rem_next = frame_rem_reg;
        idx_next       = idx_reg;
        shift_next     = shift_reg;
        tag_err_next   = tag_err_reg;
        str_rem_next   = str_rem_reg;
        sel_next       = sel_reg;
        held_ts_next   = held_ts_reg;
        held_occ_next  = held_occ_reg;
        ev_valid       = 1'b0;
        ev             = '0;
        last           = 1'b0;
        quiet          = 1'b0;

        case (phase_reg)
            PH_LEN_HI:
            begin
                shift_next = {24'd0, byte_in};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                shift_next = '0;
                idx_next   = '0;
                if (len == 16'd0)
                begin
                    // empty frame
                    phase_next   = PH_LEN_HI;
                    ev_valid     = 1'b1;
                    ev.kind      = KIND_FRAME_END;
                    ev.frame_end = 1'b1;
                    ev.malformed = 1'b1;
                end
                else
                begin
                    frame_rem_next = len;
                    phase_next     = PH_TAG;
                end
            end
            default:
            begin
                frame_rem_next = rem_dec;
                last           = (rem_dec == 16'd0);

                case (phase_reg)
                    PH_TAG:
                    begin
                        tag_err_next = (byte_in == TAG_ERROR);
                        phase_next   = (byte_in == TAG_ERROR || byte_in == TAG_PRINT)
                                       ? PH_TS : PH_IGNORE;
                        idx_next     = '0;
                        shift_next   = '0;
                    end
                    PH_TS:
                    begin
                        shift_next = shifted;
                        if (idx_reg == 2'd3)
                        begin
                            idx_next     = '0;
                            held_ts_next = shifted;
                            shift_next   = '0;
                            phase_next   = PH_SEQ;
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                    PH_SEQ:
                    begin
                        shift_next = shifted;
                        if (idx_reg != 2'd0)
                        begin
                            idx_next   = '0;
                            shift_next = '0;
                            if (tag_err_reg)
                            begin
                                str_rem_next = shifted[15:0];
                                phase_next   = PH_OCC;
                            end
                            else
                            begin
                                ev_valid     = 1'b1;
                                ev.kind      = KIND_MSG_HDR;
                                ev.timestamp = held_ts_reg;
                                ev.seq       = shifted[15:0];
                                phase_next   = PH_PRINT;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                    PH_OCC:
                    begin
                        shift_next = shifted;
                        if (idx_reg != 2'd0)
                        begin
                            idx_next      = '0;
                            held_occ_next = shifted[15:0];
                            shift_next    = '0;
                            phase_next    = PH_CODE;
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                    PH_CODE:
                    begin
                        // code stays in the shift register until the flags byte
                        shift_next = shifted;
                        if (idx_reg == 2'd3)
                        begin
                            idx_next   = '0;
                            phase_next = PH_FLAGS;
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                    PH_FLAGS:
                    begin
                        ev_valid     = 1'b1;
                        ev.kind      = KIND_ERR_HDR;
                        ev.timestamp = held_ts_reg;
                        ev.seq       = str_rem_reg;
                        ev.occ       = held_occ_reg;
                        ev.code      = shift_reg;
                        ev.flags     = byte_in;
                        str_rem_next = '0;
                        sel_next     = '0;
                        idx_next     = '0;
                        shift_next   = '0;
                        phase_next   = PH_STRLEN;
                    end
                    PH_STRLEN:
                    begin
                        shift_next = shifted;
                        if (idx_reg != 2'd0)
                        begin
                            idx_next     = '0;
                            shift_next   = '0;
                            str_rem_next = shifted[15:0];
                            if (shifted[15:0] == 16'd0)
                            begin
                                // empty string, move to the next one, or to the trailer after the third
                                if (sel_reg >= 2'd2)
                                begin
                                    phase_next = PH_TRAIL;
                                end
                                else
                                begin
                                    sel_next   = sel_reg + 2'd1;
                                    phase_next = PH_STRLEN;
                                end
                            end
                            else
                            begin
                                phase_next = PH_STRBODY;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                    PH_STRBODY:
                    begin
                        ev_valid      = 1'b1;
                        ev.kind       = KIND_TEXT;
                        ev.text_field = sel_reg;
                        ev.text_byte  = byte_in;
                        str_rem_next  = str_dec;
                        if (str_dec == 16'd0)
                        begin
                            idx_next   = '0;
                            shift_next = '0;
                            if (sel_reg >= 2'd2)
                            begin
                                phase_next = PH_TRAIL;
                            end
                            else
                            begin
                                sel_next   = sel_reg + 2'd1;
                                phase_next = PH_STRLEN;
                            end
                        end
                    end
                    PH_PRINT:
                    begin
                        ev_valid      = 1'b1;
                        ev.kind       = KIND_TEXT;
                        ev.text_field = FIELD_PRINT;
                        ev.text_byte  = byte_in;
                    end
                    PH_TRAIL:
                    begin
                        phase_next = PH_TRAIL;
                    end
                    default:
                    begin
                        // unknown tag or unused code: swallow the frame
                        phase_next = PH_IGNORE;
                    end
                endcase

                // frame end closes the record
                if (last)
                begin
                    quiet        = (phase_next == PH_IGNORE);
                    ev.frame_end = 1'b1;
                    ev.malformed = !(phase_next == PH_PRINT || phase_next == PH_TRAIL);
                    phase_next   = PH_LEN_HI;
                    idx_next     = '0;
                    shift_next   = '0;
                    str_rem_next = '0;
                    sel_next     = '0;
                    if (quiet)
                    begin
                        ev_valid = 1'b0;
                    end
                    else if (!ev_valid)
                    begin
                        ev_valid = 1'b1;
                        ev.kind  = KIND_FRAME_END;
                    end
                end

                ev.is_error = tag_err_next;
            end
        endcase
    end

    // parser state, advanced once per consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN_HI;
            frame_rem_reg <= '0;
            idx_reg       <= '0;
            shift_reg     <= '0;
            tag_err_reg   <= 1'b0;
            str_rem_reg   <= '0;
            sel_reg       <= '0;
            held_ts_reg   <= '0;
            held_occ_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            frame_rem_reg <= frame_rem_next;
            idx_reg       <= idx_next;
            shift_reg     <= shift_next;
            tag_err_reg   <= tag_err_next;
            str_rem_reg   <= str_rem_next;
            sel_reg       <= sel_next;
            held_ts_reg   <= held_ts_next;
            held_occ_reg  <= held_occ_next;
        end
    end

endmodule

/* design/log_frame_parser_unit.sv */
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | data_byte
// out     | output    | out_valid / out_ready| event_kind .. malformed
//
// one byte per clock sustained while results are taken; an accepted byte
// passes through input register, parse logic, result register
// reset (rst_n low) empties both registers and puts the parser at the
// first length byte of a frame
// a stalled result holds the result register; bytes that give no result
// still move through, a byte that gives one waits for the register to free

module log_frame_parser_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         event_kind,
    output logic               is_error,
    output logic [31:0]        timestamp_bits,
    output logic [15:0]        sequence_res,
    output logic [15:0]        occurrences,
    output logic signed [31:0] error_code,
    output logic [7:0]         error_flags,
    output logic [1:0]         text_field,
    output logic [7:0]         text_byte,
    output logic               frame_end,
    output logic               malformed
);
    import lfp_pkg::*;

    `include "log_frame_parser_unit_defines.svh"

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    lfp_event_t out_reg;
    logic       ev_valid;
    lfp_event_t ev;
    logic       advance;

    lfp_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .byte_in  (byte_reg),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    // byte moves on unless its result finds the result register full
    assign advance  = in_valid_reg && (!ev_valid || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && ev_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ev_valid)
        begin
            out_reg <= ev;
        end
    end

    // output beat
    assign out_valid      = out_valid_reg;
    assign event_kind     = out_reg.kind;
    assign is_error       = out_reg.is_error;
    assign timestamp_bits = out_reg.timestamp;
    assign sequence_res   = out_reg.seq;
    assign occurrences    = out_reg.occ;
    assign error_code     = signed'(out_reg.code);
    assign error_flags    = out_reg.flags;
    assign text_field     = out_reg.text_field;
    assign text_byte      = out_reg.text_byte;
    assign frame_end      = out_reg.frame_end;
    assign malformed      = out_reg.malformed;

    // checks
    `LFP_ASSERT_NOW(a_malformed_at_end, clk, rst_n, out_valid_reg && out_reg.malformed,
        out_reg.frame_end, "malformed without frame end")
    `LFP_ASSERT_NOW(a_err_hdr_is_error, clk, rst_n,
        out_valid_reg && out_reg.kind == KIND_ERR_HDR, out_reg.is_error,
        "error header from a print frame")
    `LFP_ASSERT_NOW(a_print_text_not_error, clk, rst_n,
        out_valid_reg && out_reg.kind == KIND_TEXT && out_reg.text_field == FIELD_PRINT,
        !out_reg.is_error, "print text inside an error frame")
    `LFP_ASSERT_NEXT(a_held_byte_kept, clk, rst_n, in_valid_reg && !advance,
        in_valid_reg && $stable(byte_reg), "held byte lost while result stalled")

endmodule
